// ===== sv/sspr_pkg.sv =====
`default_nettype none
package sspr_pkg;

   localparam int unsigned DIGITS      = 3;
   localparam int unsigned SEGMENTS    = 7;
   localparam logic [13:0] BLANK_LIMIT = 14'd999;

   // a..g from msb to lsb of a 7-bit pattern
   localparam logic [6:0] SEG_ZERO  = 7'h7E;
   localparam logic [6:0] SEG_ONE   = 7'h30;
   localparam logic [6:0] SEG_TWO   = 7'h6D;
   localparam logic [6:0] SEG_THREE = 7'h79;
   localparam logic [6:0] SEG_FOUR  = 7'h33;
   localparam logic [6:0] SEG_FIVE  = 7'h5B;
   localparam logic [6:0] SEG_SIX   = 7'h5F;
   localparam logic [6:0] SEG_SEVEN = 7'h70;
   localparam logic [6:0] SEG_EIGHT = 7'h7F;
   localparam logic [6:0] SEG_NINE  = 7'h7B;

   typedef struct packed {
      logic [13:0] number;
      logic [3:0]  display_index;
      logic [23:0] color;
      logic [7:0]  brightness;
   } req_type;

   typedef struct packed {
      logic [3:0] box_select;
      logic [5:0] pixel_position;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } rsp_type;

   // one classified frame: digits are units, tens, hundreds from lsb up
   typedef struct packed {
      logic [3:0]  box;
      logic [11:0] digits;
      logic [1:0]  shown;
      logic [23:0] scaled;
   } frame_type;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      case (digit)
         4'd0: pat = SEG_ZERO;
         4'd1: pat = SEG_ONE;
         4'd2: pat = SEG_TWO;
         4'd3: pat = SEG_THREE;
         4'd4: pat = SEG_FOUR;
         4'd5: pat = SEG_FIVE;
         4'd6: pat = SEG_SIX;
         4'd7: pat = SEG_SEVEN;
         4'd8: pat = SEG_EIGHT;
         4'd9: pat = SEG_NINE;
         default: pat = SEG_ZERO;
      endcase
      return pat;
   endfunction

   // round(sq / 255) for sq = c*c, via x/255 = (x + (x >> 8) + 1) >> 8
   function automatic logic [7:0] gamma_of_square(input logic [15:0] sq);
      logic [16:0] x;
      logic [16:0] t;
      x = {1'b0, sq} + 17'd127;
      t = x + (x >> 8) + 17'd1;
      return t[15:8];
   endfunction

endpackage
`default_nettype wire

// ===== sv/seven_segment_pixel_renderer.sv =====
`default_nettype none
// channel   ports                               direction  payload
// request   req_valid, req_stall, req_data      in         number, box, colour, brightness
// response  rsp_valid, rsp_stall, rsp_data      out        one pixel per panel position
//
// each request yields PANEL_PIXELS responses, one per cycle while rsp_stall is low, from
// the pixel walker in the back end, which moves on to the next queued frame only after its last pixel.
// the first pixel passes through the three front stages and the queue, then the output
// register. a two-entry queue lets the front take new requests while the back end
// streams. synchronous reset empties all stages; a stalled response holds.
module seven_segment_pixel_renderer #(
   parameter int unsigned PANEL_PIXELS   = 63,
   parameter int unsigned DIGIT_PIXELS   = 21,
   parameter int unsigned SEGMENT_PIXELS = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sspr_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sspr_pkg::rsp_type       rsp_data
);
   import sspr_pkg::*;

   logic      frm_valid;
   logic      frm_stall;
   frame_type frm_data;
   logic      head_valid;
   logic      head_pop;
   frame_type head_data;

   sspr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .frm_valid (frm_valid),
      .frm_stall (frm_stall),
      .frm_data  (frm_data)
   );

   sspr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frm_valid),
      .in_stall  (frm_stall),
      .in_data   (frm_data),
      .out_valid (head_valid),
      .out_pop   (head_pop),
      .out_data  (head_data)
   );

   sspr_back #(
      .PANEL_PIXELS   (PANEL_PIXELS),
      .DIGIT_PIXELS   (DIGIT_PIXELS),
      .SEGMENT_PIXELS (SEGMENT_PIXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sv/sspr_front.sv =====
`default_nettype none
module sspr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire sspr_pkg::req_type  req_data,
   output logic                    frm_valid,
   input  wire logic               frm_stall,
   output sspr_pkg::frame_type     frm_data
);
   import sspr_pkg::*;

   logic advance;

   // stage 1: squares, hundreds, digit count
   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  s1_box_ff;
   logic [7:0]  s1_bright_ff;
   logic [15:0] s1_sq_ff [3];
   logic [9:0]  s1_num_ff;
   logic [3:0]  s1_hund_ff;
   logic [1:0]  s1_shown_ff;

   // stage 2: gamma and remainder below one hundred
   logic        s2_valid_ff, s2_valid_in;
   logic [3:0]  s2_box_ff;
   logic [7:0]  s2_bright_ff;
   logic [7:0]  s2_gamma_ff [3];
   logic [6:0]  s2_rem_ff;
   logic [3:0]  s2_hund_ff;
   logic [1:0]  s2_shown_ff;

   // stage 3: brightness scaling, tens and units
   logic        s3_valid_ff, s3_valid_in;
   frame_type   s3_frame_ff;

   logic [15:0] hund_prod;
   logic [9:0]  rem_full;
   logic [13:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  units_full;
   logic [15:0] scale_prod [3];
   logic [1:0]  shown;

   assign advance   = !(s3_valid_ff && frm_stall);
   assign req_stall = !advance;
   assign frm_valid = s3_valid_ff;
   assign frm_data  = s3_frame_ff;

   assign s1_valid_in = req_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;

   // n/100 = (n*41) >> 12 holds for n below one thousand
   assign hund_prod = 16'(req_data.number[9:0]) * 16'd41;

   always_comb begin
      if (req_data.number > BLANK_LIMIT) begin
         shown = 2'd0;
      end else if (req_data.number > 14'd99) begin
         shown = 2'd3;
      end else if (req_data.number > 14'd9) begin
         shown = 2'd2;
      end else begin
         shown = 2'd1;
      end
   end

   assign rem_full = s1_num_ff - 10'(s1_hund_ff) * 10'd100;

   // r/10 = (r*103) >> 10 holds for r below one hundred
   assign tens_prod  = 14'(s2_rem_ff) * 14'd103;
   assign tens       = tens_prod[13:10];
   assign units_full = s2_rem_ff - 7'(tens) * 7'd10;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scale_prod[i] = 16'(s2_gamma_ff[i]) * 16'(s2_bright_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_box_ff    <= req_data.display_index;
         s1_bright_ff <= req_data.brightness;
         s1_sq_ff[2]  <= 16'(req_data.color[23:16]) * 16'(req_data.color[23:16]);
         s1_sq_ff[1]  <= 16'(req_data.color[15:8]) * 16'(req_data.color[15:8]);
         s1_sq_ff[0]  <= 16'(req_data.color[7:0]) * 16'(req_data.color[7:0]);
         s1_num_ff    <= req_data.number[9:0];
         s1_hund_ff   <= hund_prod[15:12];
         s1_shown_ff  <= shown;

         s2_box_ff    <= s1_box_ff;
         s2_bright_ff <= s1_bright_ff;
         for (int i = 0; i < 3; i++) begin
            s2_gamma_ff[i] <= gamma_of_square(s1_sq_ff[i]);
         end
         s2_rem_ff    <= rem_full[6:0];
         s2_hund_ff   <= s1_hund_ff;
         s2_shown_ff  <= s1_shown_ff;

         s3_frame_ff.box    <= s2_box_ff;
         s3_frame_ff.digits <= {s2_hund_ff, tens, units_full[3:0]};
         s3_frame_ff.shown  <= s2_shown_ff;
         s3_frame_ff.scaled <= {scale_prod[2][15:8], scale_prod[1][15:8],
                                scale_prod[0][15:8]};
      end
   end

endmodule
`default_nettype wire

// ===== sv/sspr_queue.sv =====
`default_nettype none
module sspr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_stall,
   input  wire sspr_pkg::frame_type  in_data,
   output logic                      out_valid,
   input  wire logic                 out_pop,
   output sspr_pkg::frame_type       out_data
);
   import sspr_pkg::*;

   frame_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];

   assign push = in_valid && !in_stall;
   assign pop  = out_pop && out_valid;

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/sspr_back.sv =====
`default_nettype none
module sspr_back #(
   parameter int unsigned PANEL_PIXELS   = 63,
   parameter int unsigned DIGIT_PIXELS   = 21,
   parameter int unsigned SEGMENT_PIXELS = 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire sspr_pkg::frame_type  head_data,
   output logic                      head_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sspr_pkg::rsp_type         rsp_data
);
   import sspr_pkg::*;

   localparam int unsigned SUB_W = $clog2(SEGMENT_PIXELS + 1);
   localparam int unsigned OFF_W = $clog2(DIGIT_PIXELS + 1);
   localparam int unsigned DIG_W = $clog2(PANEL_PIXELS / DIGIT_PIXELS + 1);

   logic [5:0]       pos_ff, pos_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [OFF_W-1:0] seg_ff, seg_in;
   logic [SUB_W-1:0] sub_ff, sub_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic       load;
   logic       last;
   logic       lit;
   logic [3:0] digit;
   logic [6:0] pat;
   logic [7:0] dig_wide;

   assign last     = (pos_ff == 6'(PANEL_PIXELS - 1));
   assign load     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign head_pop = load && last;
   assign dig_wide = 8'(dig_ff);

   always_comb begin
      case (dig_wide)
         8'd0:    digit = head_data.digits[3:0];
         8'd1:    digit = head_data.digits[7:4];
         default: digit = head_data.digits[11:8];
      endcase
   end

   assign pat = seg_pattern(digit);

   always_comb begin
      lit = 1'b0;
      if (dig_wide < 8'(DIGITS) && dig_wide < 8'(head_data.shown) &&
          seg_ff < OFF_W'(SEGMENTS)) begin
         lit = pat[3'(SEGMENTS - 1) - seg_ff[2:0]];
      end
   end

   // walk position, digit, segment and pixel-in-segment together
   always_comb begin
      pos_in = pos_ff;
      dig_in = dig_ff;
      off_in = off_ff;
      seg_in = seg_ff;
      sub_in = sub_ff;
      if (load) begin
         if (last) begin
            pos_in = '0;
            dig_in = '0;
            off_in = '0;
            seg_in = '0;
            sub_in = '0;
         end else begin
            pos_in = pos_ff + 6'd1;
            if (off_ff == OFF_W'(DIGIT_PIXELS - 1)) begin
               dig_in = dig_ff + DIG_W'(1);
               off_in = '0;
               seg_in = '0;
               sub_in = '0;
            end else begin
               off_in = off_ff + OFF_W'(1);
               if (sub_ff == SUB_W'(SEGMENT_PIXELS - 1)) begin
                  sub_in = '0;
                  seg_in = seg_ff + OFF_W'(1);
               end else begin
                  sub_in = sub_ff + SUB_W'(1);
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         dig_ff       <= '0;
         off_ff       <= '0;
         seg_ff       <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         dig_ff       <= dig_in;
         off_ff       <= off_in;
         seg_ff       <= seg_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.box_select     <= head_data.box;
         rsp_data_ff.pixel_position <= pos_ff;
         rsp_data_ff.red            <= lit ? head_data.scaled[23:16] : 8'd0;
         rsp_data_ff.green          <= lit ? head_data.scaled[15:8] : 8'd0;
         rsp_data_ff.blue           <= lit ? head_data.scaled[7:0] : 8'd0;
         rsp_data_ff.frame_end      <= last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
